// ----- rtl/core/cbt_pkg.sv -----
// Shared types and constants for the CAN bit-timing sequencer.
package cbt_pkg;

   // Width of the quantum counter and the phase target.
   localparam int CNT_W = 5;

   localparam int SEG_W  = 3;
   localparam int S1_W   = 5;
   localparam int S2_W   = 4;
   localparam int JW_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   // Segment codes.
   localparam logic [SEG_W-1:0] SEG_SYNC    = 3'd0;
   localparam logic [SEG_W-1:0] SEG_SEG1    = 3'd1;
   localparam logic [SEG_W-1:0] SEG_SEG2    = 3'd2;
   localparam logic [SEG_W-1:0] SEG_DELAY   = 3'd3;
   localparam logic [SEG_W-1:0] SEG_ADVANCE = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SEG1_QUANTA = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEG2_QUANTA = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_JUMP_WIDTH  = 2'd2;

   // Configuration reset values.
   localparam logic [S1_W-1:0] SEG1_RESET = 5'd6;
   localparam logic [S2_W-1:0] SEG2_RESET = 4'd4;
   localparam logic [JW_W-1:0] JW_RESET   = 3'd1;

   typedef struct packed {
      logic edge_seen;
      logic idle_at_edge;
   } req_type;

   typedef struct packed {
      logic             write_pulse;
      logic             sample_pulse;
      logic [SEG_W-1:0] segment;
   } rsp_type;

   typedef struct packed {
      logic [S1_W-1:0] seg1_quanta;
      logic [S2_W-1:0] seg2_quanta;
      logic [JW_W-1:0] jump_width;
   } cfg_type;

endpackage

// ----- rtl/core/can_bit_timing_sync.sv -----
// Top level of the CAN bit-timing sequencer: input register, step logic, result register.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_type: edge_seen, idle_at_edge
//   rsp      out        rsp_valid / rsp_stall  rsp_type: write_pulse, sample_pulse, segment
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// Each item is held in the input register and its result is captured in the result
// register: one item per cycle while the result is not stalled.
// The segment state advances when an item moves from the input to the result register.
// Reset is synchronous; it clears the state and loads the register defaults.
// A stalled result holds both stages; req_stall rises only when the input stage is full.
module can_bit_timing_sync (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  cbt_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output cbt_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cbt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cbt_pkg::CSR_DATA_W-1:0] csr_data
);

   cbt_pkg::cfg_type cfg;
   cbt_pkg::req_type item_ff;
   cbt_pkg::rsp_type result;
   cbt_pkg::rsp_type rsp_ff;
   logic             item_valid_ff;
   logic             rsp_valid_ff;
   logic             out_free;
   logic             advance;

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign advance   = item_valid_ff & out_free;
   assign req_stall = item_valid_ff & ~out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   cbt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cbt_step u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (~req_stall) begin
            item_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= advance;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & ~req_stall) begin
         item_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

endmodule

// ----- rtl/core/cbt_csr.sv -----
// Configuration registers of the CAN bit-timing sequencer.
module cbt_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cbt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cbt_pkg::CSR_DATA_W-1:0]   csr_data,
   output cbt_pkg::cfg_type                 cfg
);

   cbt_pkg::cfg_type cfg_ff;
   cbt_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            cbt_pkg::CSR_SEG1_QUANTA: cfg_in.seg1_quanta = csr_data[cbt_pkg::S1_W-1:0];
            cbt_pkg::CSR_SEG2_QUANTA: cfg_in.seg2_quanta = csr_data[cbt_pkg::S2_W-1:0];
            cbt_pkg::CSR_JUMP_WIDTH:  cfg_in.jump_width  = csr_data[cbt_pkg::JW_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.seg1_quanta <= cbt_pkg::SEG1_RESET;
         cfg_ff.seg2_quanta <= cbt_pkg::SEG2_RESET;
         cfg_ff.jump_width  <= cbt_pkg::JW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/core/cbt_step.sv -----
// Segment state and the per-tick sequencing logic of the bit-timing sequencer.
module cbt_step (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  cbt_pkg::req_type item,
   input  cbt_pkg::cfg_type cfg,
   output cbt_pkg::rsp_type result
);

   logic [cbt_pkg::SEG_W-1:0] segment_ff, segment_in;
   logic [cbt_pkg::CNT_W-1:0] count_ff, count_in;
   logic [cbt_pkg::CNT_W-1:0] target_ff, target_in;
   logic                      soft_ff, soft_in;

   logic                      hard;
   logic                      soft_sync;
   logic [cbt_pkg::SEG_W-1:0] seg;
   logic [cbt_pkg::CNT_W-1:0] cnt_inc;
   logic [cbt_pkg::CNT_W-1:0] s1_ext;
   logic [cbt_pkg::CNT_W-1:0] s2_ext;
   logic [cbt_pkg::CNT_W-1:0] jw_ext;
   logic [cbt_pkg::CNT_W-1:0] jump;
   logic [cbt_pkg::CNT_W-1:0] late_target;
   logic [cbt_pkg::CNT_W-1:0] early_target;
   logic                      wr;
   logic                      smp;

   always_comb begin
      hard      = item.edge_seen & item.idle_at_edge;
      soft_sync = soft_ff | (item.edge_seen & ~item.idle_at_edge);
      // A hard sync restarts the bit at the sync segment before the tick runs.
      seg     = hard ? cbt_pkg::SEG_SYNC : segment_ff;
      cnt_inc = (hard ? '0 : count_ff) + cbt_pkg::CNT_W'(1);
      s1_ext  = cbt_pkg::CNT_W'(cfg.seg1_quanta);
      s2_ext  = cbt_pkg::CNT_W'(cfg.seg2_quanta);
      jw_ext  = cbt_pkg::CNT_W'(cfg.jump_width);
      jump    = (jw_ext < cnt_inc) ? jw_ext : cnt_inc;
      late_target  = s1_ext + jump;
      early_target = s2_ext - jump;

      segment_in = seg;
      count_in   = cnt_inc;
      target_in  = target_ff;
      soft_in    = soft_sync;
      wr         = 1'b0;
      smp        = 1'b0;

      case (seg)
         cbt_pkg::SEG_SEG1: begin
            if (soft_sync) begin
               soft_in    = 1'b0;
               target_in  = late_target;
               segment_in = cbt_pkg::SEG_DELAY;
            end else if (cnt_inc == s1_ext) begin
               smp        = 1'b1;
               count_in   = '0;
               segment_in = cbt_pkg::SEG_SEG2;
            end
         end
         cbt_pkg::SEG_SEG2: begin
            if (soft_sync) begin
               soft_in   = 1'b0;
               target_in = early_target;
               // Resync late in seg2 goes straight back to seg1.
               if (cnt_inc >= early_target) begin
                  count_in   = '0;
                  segment_in = cbt_pkg::SEG_SEG1;
               end else begin
                  segment_in = cbt_pkg::SEG_ADVANCE;
               end
            end else if (cnt_inc == s2_ext) begin
               segment_in = cbt_pkg::SEG_SYNC;
            end
         end
         cbt_pkg::SEG_DELAY: begin
            if (cnt_inc == target_ff) begin
               smp        = 1'b1;
               count_in   = '0;
               segment_in = cbt_pkg::SEG_SEG2;
            end
         end
         cbt_pkg::SEG_ADVANCE: begin
            if (cnt_inc == target_ff) begin
               count_in   = '0;
               segment_in = cbt_pkg::SEG_SEG1;
            end
         end
         default: begin
            wr         = 1'b1;
            count_in   = '0;
            segment_in = cbt_pkg::SEG_SEG1;
         end
      endcase

      result.write_pulse  = wr;
      result.sample_pulse = smp;
      result.segment      = segment_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         segment_ff <= cbt_pkg::SEG_SYNC;
         count_ff   <= '0;
         target_ff  <= '0;
         soft_ff    <= 1'b0;
      end else if (advance) begin
         segment_ff <= segment_in;
         count_ff   <= count_in;
         target_ff  <= target_in;
         soft_ff    <= soft_in;
      end
   end

endmodule
